// ----- rtl/psu_pkg.sv -----
package psu_pkg;

  // Default particle count and field widths.
  localparam int PARTICLES_DEF = 32;
  localparam int TIME_W        = 32;
  localparam int POS_W         = 24;
  localparam int AGE_W         = 16;
  localparam int Q_SHIFT       = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 2'd1;

  localparam logic [TIME_W-1:0] SPAWN_INTERVAL_RST = 32'd10240;
  localparam logic [31:0]       RANDOM_SEED_RST    = 32'd1;

  // Random generator: Galois LFSR shifting right, eight steps per advancing cycle.
  localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
  localparam int          LFSR_STEPS = 8;

  // Step scaling: 0.2 and 0.1 in Q0.16.
  localparam int AGE_SCALE_W = 14;
  localparam int DRAG_MULT_W = 13;
  localparam logic [AGE_SCALE_W-1:0] AGE_SCALE = 14'd13107;
  localparam logic [DRAG_MULT_W-1:0] DRAG_MULT = 13'd6554;
  localparam int AGE_INC_W = TIME_W + AGE_SCALE_W - Q_SHIFT;
  localparam int DRAG_W    = TIME_W + DRAG_MULT_W - Q_SHIFT;
  localparam int FACT_W    = DRAG_W + 1;
  localparam logic signed [FACT_W-1:0] Q_ONE_F = 30'sd65536;

  // Respawn velocity offsets: 1.0 for x and z, 6.0 for y.
  localparam logic signed [POS_W-1:0] VX_BASE = 24'sd65536;
  localparam logic signed [POS_W-1:0] VY_BASE = 24'sd393216;

  typedef logic signed [POS_W-1:0] s24_t;
  typedef s24_t [2:0] vec3_t;

  typedef struct packed {
    vec3_t            pos;
    vec3_t            vel;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FACT,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_RNG,
    ST_WRITE
  } state_t;

endpackage

// ----- rtl/particle_system_update_unit.sv -----
// Particle system update unit.
//
// One input transfer on the in_ channel carries a frame time in unsigned
// Q16.16 seconds. The unit derives the step from the previous frame time,
// ages, drags and moves every live particle, respawns those whose age
// reaches one, may append one new particle, and then has delivered one
// out_ transfer per live particle in index order, with out_last set on the
// final one. A frame with no live particles produces no transfer.
// Each existing particle costs one read-modify-write of the particle
// memory through the sequencer: a surviving one passes the drag and
// position datapath, a respawned one takes three random draws. An
// appended particle takes the three draws and is only written, not read.
// in_stall is high while a frame is being processed.
// A result waits in an output register; while the receiver stalls, the
// unit goes on with the next particle and holds only at its next result.
// Reset clears the live count, the stored times and the output valid, and
// loads the random generator with one; the particle memory is not cleared.
module particle_system_update_unit import psu_pkg::*; #(
  parameter int  PARTICLES = PARTICLES_DEF,
  localparam int IDX_W     = (PARTICLES > 1) ? $clog2(PARTICLES) : 1,
  localparam int CNT_W     = $clog2(PARTICLES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_frame_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      out_particle_index,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  output logic [AGE_W-1:0]      out_particle_age,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Random draw schedule: x is taken after two advances, y after four and
  // z after six, when the respawned entry is assembled.
  localparam logic [2:0] RNG_X_AT = 3'd2;
  localparam logic [2:0] RNG_Y_AT = 3'd4;
  localparam logic [2:0] RNG_END  = 3'd6;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]        spawn_interval_r;
  logic [TIME_W-1:0]        last_frame_r;
  logic [TIME_W-1:0]        last_spawn_r;
  logic [TIME_W-1:0]        now_r;
  logic [TIME_W-1:0]        dt_r;
  logic [AGE_INC_W-1:0]     age_inc_r;
  logic [DRAG_W-1:0]        drag_r;
  logic signed [FACT_W-1:0] factor_r;
  logic [CNT_W-1:0]         live_r;
  logic [CNT_W-1:0]         old_live_r;
  logic [CNT_W-1:0]         total_r;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [2:0]               rcnt_r, rcnt_nxt;
  logic [AGE_W-1:0]         rx_r;
  logic [AGE_W-1:0]         ry_r;
  logic [AGE_W-1:0]         age_new_r;
  entry_t                   entry_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  vec3_t                    out_pos_r;
  logic [AGE_W-1:0]         out_age_r;
  logic                     out_last_r;

  // Sequencer controls.
  logic in_go;
  logic mem_re;
  logic dp_start;
  logic rng_adv;
  logic wr_go;

  logic                          out_free;
  logic                          alive;
  logic                          spawn;
  logic [AGE_INC_W:0]            age_sum;
  logic [TIME_W+AGE_SCALE_W-1:0] age_prod;
  logic [TIME_W+DRAG_MULT_W-1:0] drag_prod;
  logic                          is_last;
  logic                          rng_load;

  entry_t      rd_data;
  logic        dp_done;
  vec3_t       dp_pos;
  vec3_t       dp_vel;
  logic [31:0] rng_state;

  // ---------------------------------------------------------------------
  // Frame-level arithmetic
  // ---------------------------------------------------------------------
  // The step is scaled by 0.2 for aging and by 0.1 for drag, both
  // truncated to Q16.16 (the products are never negative).
  assign age_prod  = (TIME_W+AGE_SCALE_W)'(dt_r) * (TIME_W+AGE_SCALE_W)'(AGE_SCALE);
  assign drag_prod = (TIME_W+DRAG_MULT_W)'(dt_r) * (TIME_W+DRAG_MULT_W)'(DRAG_MULT);

  // A particle is appended when a slot is free and strictly more than the
  // spawn interval has gone by since the last spawn, modulo 2^32.
  assign spawn = (live_r < CNT_W'(PARTICLES)) &&
                 ((now_r - last_spawn_r) > spawn_interval_r);

  // The particle survives while its new age stays below one.
  assign age_sum = (AGE_INC_W+1)'(rd_data.age) + (AGE_INC_W+1)'(age_inc_r);
  assign alive   = (age_sum[AGE_INC_W:AGE_W] == '0);

  assign is_last  = ({1'b0, idx_r} + (CNT_W+1)'(1)) == {1'b0, total_r};
  assign out_free = !out_valid_r || !out_stall;
  assign rng_load = cfg_we && (cfg_index == CFG_RANDOM_SEED);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_FACT;
      ST_FACT:  state_nxt = ST_READ;
      ST_READ: begin
        // Existing particles first, then the appended one, then done.
        priority if (idx_r < old_live_r) begin
          state_nxt = ST_WAIT;
        end else if (idx_r < total_r) begin
          state_nxt = ST_RNG;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        state_nxt = alive ? ST_CALC : ST_RNG;
      end
      ST_CALC: begin
        if (dp_done) state_nxt = ST_WRITE;
      end
      ST_RNG: begin
        if (rcnt_r == RNG_END) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) state_nxt = ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_go    = 1'b0;
    mem_re   = 1'b0;
    dp_start = 1'b0;
    rng_adv  = 1'b0;
    wr_go    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_go    = in_valid;
      ST_READ:  mem_re   = (idx_r < old_live_r);
      ST_WAIT:  dp_start = alive;
      ST_RNG:   rng_adv  = (rcnt_r < RNG_END);
      ST_WRITE: wr_go    = out_free;
      default: begin
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    idx_nxt = idx_r;
    if (state_r == ST_PREP) begin
      idx_nxt = '0;
    end else if (wr_go) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  assign rcnt_nxt = (state_r == ST_RNG) ? rcnt_r + 3'd1 : 3'd0;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      spawn_interval_r <= SPAWN_INTERVAL_RST;
      last_frame_r     <= '0;
      last_spawn_r     <= '0;
      live_r           <= '0;
      idx_r            <= '0;
      rcnt_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rcnt_r  <= rcnt_nxt;
      if (cfg_we && (cfg_index == CFG_SPAWN_INTERVAL)) begin
        spawn_interval_r <= cfg_wdata[TIME_W-1:0];
      end
      if (in_go) begin
        last_frame_r <= in_frame_time;
      end
      // The spawn decision and the new live count are settled before the
      // walk starts; the walk itself uses old_live_r and total_r.
      if (state_r == ST_PREP) begin
        live_r <= live_r + CNT_W'(spawn);
        if (spawn) begin
          last_spawn_r <= now_r;
        end
      end
      if (wr_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_go) begin
      now_r <= in_frame_time;
      dt_r  <= in_frame_time - last_frame_r;
    end
    if (state_r == ST_PREP) begin
      age_inc_r  <= age_prod[TIME_W+AGE_SCALE_W-1:Q_SHIFT];
      drag_r     <= drag_prod[TIME_W+DRAG_MULT_W-1:Q_SHIFT];
      old_live_r <= live_r;
      total_r    <= live_r + CNT_W'(spawn);
    end
    if (state_r == ST_FACT) begin
      // The drag factor goes negative for very long steps.
      factor_r <= Q_ONE_F - $signed({1'b0, drag_r});
    end
    if (state_r == ST_WAIT) begin
      age_new_r <= age_sum[AGE_W-1:0];
    end
    if ((state_r == ST_CALC) && dp_done) begin
      entry_r.pos <= dp_pos;
      entry_r.vel <= dp_vel;
      entry_r.age <= age_new_r;
    end
    if (state_r == ST_RNG) begin
      if (rcnt_r == RNG_X_AT) begin
        rx_r <= rng_state[AGE_W-1:0];
      end
      if (rcnt_r == RNG_Y_AT) begin
        ry_r <= rng_state[AGE_W-1:0];
      end
      // A respawned particle starts at the origin with age zero and a
      // velocity of (1 - 2rx, 6 - 2ry, 1 - 2rz).
      if (rcnt_r == RNG_END) begin
        entry_r.pos    <= '0;
        entry_r.vel[0] <= VX_BASE - $signed({7'b0, rx_r, 1'b0});
        entry_r.vel[1] <= VY_BASE - $signed({7'b0, ry_r, 1'b0});
        entry_r.vel[2] <= VX_BASE - $signed({7'b0, rng_state[AGE_W-1:0], 1'b0});
        entry_r.age    <= '0;
      end
    end
    if (wr_go) begin
      out_idx_r  <= idx_r[IDX_W-1:0];
      out_pos_r  <= entry_r.pos;
      out_age_r  <= entry_r.age;
      out_last_r <= is_last;
    end
  end

  // ---------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------
  psu_store #(
    .DEPTH (PARTICLES),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .re    (mem_re),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rd_data),
    .we    (wr_go),
    .waddr (idx_r[IDX_W-1:0]),
    .wdata (entry_r)
  );

  psu_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dp_start),
    .cur    (rd_data),
    .factor (factor_r),
    .dt     (dt_r),
    .done   (dp_done),
    .pos_o  (dp_pos),
    .vel_o  (dp_vel)
  );

  psu_rng u_rng (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (rng_load),
    .seed  (cfg_wdata[31:0]),
    .adv   (rng_adv),
    .state (rng_state)
  );

  assign out_valid          = out_valid_r;
  assign out_particle_index = out_idx_r;
  assign out_pos_x          = out_pos_r[0];
  assign out_pos_y          = out_pos_r[1];
  assign out_pos_z          = out_pos_r[2];
  assign out_particle_age   = out_age_r;
  assign out_last           = out_last_r;

endmodule

// ----- rtl/psu_store.sv -----
module psu_store import psu_pkg::*; #(
  parameter int DEPTH = PARTICLES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata
);

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/psu_rng.sv -----
module psu_rng import psu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] seed,
  input  logic        adv,
  output logic [31:0] state
);

  logic [31:0] state_r;
  logic [31:0] state_nxt;

  // Eight shifts of the register in each cycle that adv is high.
  always_comb begin
    state_nxt = state_r;
    for (int k = 0; k < LFSR_STEPS; k++) begin
      if (state_nxt[0]) begin
        state_nxt = (state_nxt >> 1) ^ LFSR_MASK;
      end else begin
        state_nxt = state_nxt >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RANDOM_SEED_RST;
    end else if (load) begin
      state_r <= seed;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

// ----- rtl/psu_dp.sv -----
module psu_dp import psu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  entry_t                   cur,
  input  logic signed [FACT_W-1:0] factor,
  input  logic [TIME_W-1:0]        dt,
  output logic                     done,
  output vec3_t                    pos_o,
  output vec3_t                    vel_o
);

  localparam int VPROD_W = POS_W + FACT_W;
  localparam int PPROD_W = POS_W + TIME_W + 1;
  localparam int SUM_W   = PPROD_W - Q_SHIFT + 1;
  localparam logic signed [SUM_W-1:0] S24_MAX = 42'sd8388607;
  localparam logic signed [SUM_W-1:0] S24_MIN = -42'sd8388608;

  function automatic s24_t sat24(input logic signed [SUM_W-1:0] x);
    s24_t res;
    priority if (x > S24_MAX) begin
      res = S24_MAX[POS_W-1:0];
    end else if (x < S24_MIN) begin
      res = S24_MIN[POS_W-1:0];
    end else begin
      res = x[POS_W-1:0];
    end
    return res;
  endfunction

  logic [3:0]                stg_r;
  logic signed [VPROD_W-1:0] vprod_r [3];
  logic signed [PPROD_W-1:0] pprod_r [3];
  vec3_t                     pos_r;
  vec3_t                     vnew_r;
  vec3_t                     posn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[2:0], start};
    end
  end

  // Drag multiply, saturate, position multiply, then add and saturate.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (start) begin
        vprod_r[c] <= $signed(cur.vel[c]) * factor;
      end
      if (stg_r[0]) begin
        vnew_r[c] <= sat24(SUM_W'(vprod_r[c] >>> Q_SHIFT));
      end
      if (stg_r[1]) begin
        pprod_r[c] <= $signed(vnew_r[c]) * $signed({1'b0, dt});
      end
      if (stg_r[2]) begin
        posn_r[c] <= sat24(SUM_W'($signed(pos_r[c])) + SUM_W'(pprod_r[c] >>> Q_SHIFT));
      end
    end
    if (start) begin
      pos_r <= cur.pos;
    end
  end

  assign done  = stg_r[3];
  assign pos_o = posn_r;
  assign vel_o = vnew_r;

endmodule

// ----- rtl/psu_checker.sv -----
module psu_checker import psu_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [POS_W-1:0] out_pos_x,
  input logic signed [POS_W-1:0] out_pos_y,
  input logic signed [POS_W-1:0] out_pos_z,
  input logic [AGE_W-1:0]       out_particle_age,
  input logic                   out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y) &&
      $stable(out_pos_z) && $stable(out_particle_age) && $stable(out_last))
    else $error("stalled result changed");

  // Reset leaves the unit idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not idle after reset");

  // An accepted frame keeps the unit busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit not busy after frame transfer");

  // While idle, only the final result of a frame can still be waiting.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_last)
    else $error("idle with a non-final result pending");

endmodule

bind particle_system_update_unit psu_checker u_psu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pos_x        (out_pos_x),
  .out_pos_y        (out_pos_y),
  .out_pos_z        (out_pos_z),
  .out_particle_age (out_particle_age),
  .out_last         (out_last)
);
